>>> rtl/pdd_pkg.sv
package pdd_pkg;

	localparam int POS_W  = 24;
	localparam int DIFF_W = POS_W + 1;
	localparam int MAG_W  = POS_W;
	localparam int SQ_W   = 2 * MAG_W + 2;
	localparam int QUAT_W = 16;
	localparam int SPC_W  = 20;
	localparam int THR_W  = 2 * SPC_W;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic [SPC_W-1:0] CLOUD_SPACING_RST    = 20'd1000;
	localparam logic [SPC_W-1:0] WAYPOINT_SPACING_RST = 20'd4000;
	localparam logic [THR_W-1:0] CLOUD_THR_RST        = 40'd1000000;
	localparam logic [THR_W-1:0] WAYPOINT_THR_RST     = 40'd16000000;

	// register select is byte address bit 2
	typedef enum logic {
		REG_CLOUD_SPACING    = 1'b0,
		REG_WAYPOINT_SPACING = 1'b1
	} reg_idx_t;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [DIFF_W-1:0] rel_t;
	typedef logic signed [QUAT_W-1:0] quat_t;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
	} pos3_t;

endpackage

>>> rtl/pdd_pose_if.sv
interface pdd_pose_if;

	logic          valid;
	logic          ready;
	pdd_pkg::pos_t  pos_x;
	pdd_pkg::pos_t  pos_y;
	pdd_pkg::pos_t  pos_z;
	pdd_pkg::quat_t quat_z;
	pdd_pkg::quat_t quat_w;

	modport source (output valid, pos_x, pos_y, pos_z, quat_z, quat_w, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, quat_z, quat_w, output ready);

endinterface

>>> rtl/pdd_result_if.sv
interface pdd_result_if;

	logic           valid;
	logic           ready;
	logic           keep_cloud;
	logic           new_waypoint;
	pdd_pkg::rel_t  rel_x;
	pdd_pkg::rel_t  rel_y;
	pdd_pkg::quat_t wp_quat_z;
	pdd_pkg::quat_t wp_quat_w;

	modport source (output valid, keep_cloud, new_waypoint, rel_x, rel_y, wp_quat_z,
		wp_quat_w, input ready);
	modport sink (input valid, keep_cloud, new_waypoint, rel_x, rel_y, wp_quat_z,
		wp_quat_w, output ready);

endinterface

>>> rtl/pdd_dist_gate.sv
module pdd_dist_gate (
	input  pdd_pkg::pos3_t                   cur,
	input  pdd_pkg::pos3_t                   anchor,
	input  logic [pdd_pkg::THR_W-1:0]        thr_sq,
	output logic                             pass
);

	logic [pdd_pkg::DIFF_W-1:0] dx, dy, dz;
	logic [pdd_pkg::MAG_W-1:0]  mx, my, mz;
	logic [2*pdd_pkg::MAG_W-1:0] sx, sy, sz;
	logic [pdd_pkg::SQ_W-1:0]   dist_sq;

	assign dx = {cur.x[pdd_pkg::POS_W-1], cur.x} - {anchor.x[pdd_pkg::POS_W-1], anchor.x};
	assign dy = {cur.y[pdd_pkg::POS_W-1], cur.y} - {anchor.y[pdd_pkg::POS_W-1], anchor.y};
	assign dz = {cur.z[pdd_pkg::POS_W-1], cur.z} - {anchor.z[pdd_pkg::POS_W-1], anchor.z};

	// magnitude of a difference of two 24-bit values never exceeds 2^24-1
	always_comb begin
		mx = dx[pdd_pkg::DIFF_W-1] ? pdd_pkg::MAG_W'(-dx) : dx[pdd_pkg::MAG_W-1:0];
		my = dy[pdd_pkg::DIFF_W-1] ? pdd_pkg::MAG_W'(-dy) : dy[pdd_pkg::MAG_W-1:0];
		mz = dz[pdd_pkg::DIFF_W-1] ? pdd_pkg::MAG_W'(-dz) : dz[pdd_pkg::MAG_W-1:0];
	end

	assign sx = mx * mx;
	assign sy = my * my;
	assign sz = mz * mz;

	assign dist_sq = pdd_pkg::SQ_W'(sx) + pdd_pkg::SQ_W'(sy) + pdd_pkg::SQ_W'(sz);
	assign pass    = (dist_sq >= pdd_pkg::SQ_W'(thr_sq));

endmodule

>>> rtl/pose_distance_decimator_core.sv
// Pose distance decimator.
// Input channel "pose" carries one pose per transaction (x, y, z in mm, quaternion
// z and w). Output channel "result" returns exactly one transaction per pose:
// keep_cloud from the 3D spacing filter, new_waypoint from the 2D spacing filter,
// and for a waypoint its x/y offset from the first waypoint plus the quaternion.
// Both channels use valid/ready; a transaction moves when both are high.
// A pose accepted into the input register has its result loaded into the result
// register after one combinational pass (subtract, square, sum, compare).
// Throughput is one pose per cycle while the receiver does not stall; the
// filter state loop (last kept position -> squared distance -> compare -> update)
// closes in that one pass.
// The APB port holds cloud_spacing (0x0) and waypoint_spacing (0x4); squared
// thresholds are formed on the write. Write only while the block is idle.
// Reset clears both filters (next pose is a first cloud and a first waypoint)
// and restores spacings 1000 and 4000. When the receiver stalls, the result
// register holds; an empty input register still takes one more pose, then ready drops.
module pose_distance_decimator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	pdd_pose_if.sink                      pose,
	pdd_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdd_pkg::APB_AW-1:0]    paddr,
	input  logic [pdd_pkg::APB_DW-1:0]    pwdata,
	output logic [pdd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	// configuration
	logic [pdd_pkg::SPC_W-1:0] cloud_spacing_q, waypoint_spacing_q;
	logic [pdd_pkg::THR_W-1:0] cloud_thr_q, waypoint_thr_q;
	logic [pdd_pkg::SPC_W-1:0] wr_spacing;
	logic [pdd_pkg::THR_W-1:0] wr_thr;
	logic                      cfg_wr;
	pdd_pkg::reg_idx_t         reg_sel;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite;
	assign reg_sel    = pdd_pkg::reg_idx_t'(paddr[2]);
	assign wr_spacing = pwdata[pdd_pkg::SPC_W-1:0];
	assign wr_thr     = pdd_pkg::THR_W'(wr_spacing) * pdd_pkg::THR_W'(wr_spacing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cloud_spacing_q    <= pdd_pkg::CLOUD_SPACING_RST;
			waypoint_spacing_q <= pdd_pkg::WAYPOINT_SPACING_RST;
			cloud_thr_q        <= pdd_pkg::CLOUD_THR_RST;
			waypoint_thr_q     <= pdd_pkg::WAYPOINT_THR_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				pdd_pkg::REG_CLOUD_SPACING: begin
					cloud_spacing_q <= wr_spacing;
					cloud_thr_q     <= wr_thr;
				end
				pdd_pkg::REG_WAYPOINT_SPACING: begin
					waypoint_spacing_q <= wr_spacing;
					waypoint_thr_q     <= wr_thr;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			pdd_pkg::REG_CLOUD_SPACING:    prdata = pdd_pkg::APB_DW'(cloud_spacing_q);
			pdd_pkg::REG_WAYPOINT_SPACING: prdata = pdd_pkg::APB_DW'(waypoint_spacing_q);
			default:                       prdata = '0;
		endcase
	end

	// input register
	logic           valid_s1;
	pdd_pkg::pos3_t pos_s1;
	pdd_pkg::quat_t quat_z_s1, quat_w_s1;
	logic           advance;
	logic           take_in;

	assign advance    = !result.valid || result.ready;
	assign pose.ready = !valid_s1 || advance;
	assign take_in    = pose.valid && pose.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pose.ready) begin
			valid_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pos_s1    <= '{x: pose.pos_x, y: pose.pos_y, z: pose.pos_z};
			quat_z_s1 <= pose.quat_z;
			quat_w_s1 <= pose.quat_w;
		end
	end

	// filter state
	logic           have_cloud_q, have_wp_q;
	pdd_pkg::pos3_t last_cloud_q;
	pdd_pkg::pos_t  wp_anchor_x_q, wp_anchor_y_q, wp_origin_x_q, wp_origin_y_q;

	logic           cloud_far, wp_far;
	logic           keep, wp;
	pdd_pkg::pos3_t cur_2d, last_wp_2d;
	pdd_pkg::pos_t  first_x, first_y;
	logic           step;

	assign cur_2d     = '{x: pos_s1.x, y: pos_s1.y, z: '0};
	assign last_wp_2d = '{x: wp_anchor_x_q, y: wp_anchor_y_q, z: '0};

	pdd_dist_gate u_cloud_gate (
		.cur    (pos_s1),
		.anchor (last_cloud_q),
		.thr_sq (cloud_thr_q),
		.pass   (cloud_far)
	);

	pdd_dist_gate u_wp_gate (
		.cur    (cur_2d),
		.anchor (last_wp_2d),
		.thr_sq (waypoint_thr_q),
		.pass   (wp_far)
	);

	assign step    = valid_s1 && advance;
	assign keep    = !have_cloud_q || cloud_far;
	assign wp      = !have_wp_q || wp_far;
	// the first waypoint is its own origin
	assign first_x = have_wp_q ? wp_origin_x_q : pos_s1.x;
	assign first_y = have_wp_q ? wp_origin_y_q : pos_s1.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_cloud_q  <= 1'b0;
			have_wp_q     <= 1'b0;
			last_cloud_q  <= '0;
			wp_anchor_x_q <= '0;
			wp_anchor_y_q <= '0;
			wp_origin_x_q <= '0;
			wp_origin_y_q <= '0;
		end else if (step) begin
			if (keep) begin
				have_cloud_q <= 1'b1;
				last_cloud_q <= pos_s1;
			end
			if (wp) begin
				have_wp_q     <= 1'b1;
				wp_anchor_x_q <= pos_s1.x;
				wp_anchor_y_q <= pos_s1.y;
				wp_origin_x_q <= first_x;
				wp_origin_y_q <= first_y;
			end
		end
	end

	// result register
	logic           out_valid_q;
	logic           keep_q, wp_q;
	pdd_pkg::rel_t  rel_x_q, rel_y_q;
	pdd_pkg::quat_t wp_quat_z_q, wp_quat_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			keep_q <= keep;
			wp_q   <= wp;
			if (wp) begin
				rel_x_q     <= {pos_s1.x[pdd_pkg::POS_W-1], pos_s1.x}
					- {first_x[pdd_pkg::POS_W-1], first_x};
				rel_y_q     <= {pos_s1.y[pdd_pkg::POS_W-1], pos_s1.y}
					- {first_y[pdd_pkg::POS_W-1], first_y};
				wp_quat_z_q <= quat_z_s1;
				wp_quat_w_q <= quat_w_s1;
			end else begin
				rel_x_q     <= '0;
				rel_y_q     <= '0;
				wp_quat_z_q <= '0;
				wp_quat_w_q <= '0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.keep_cloud   = keep_q;
	assign result.new_waypoint = wp_q;
	assign result.rel_x        = rel_x_q;
	assign result.rel_y        = rel_y_q;
	assign result.wp_quat_z    = wp_quat_z_q;
	assign result.wp_quat_w    = wp_quat_w_q;

endmodule
